// ===== rtl/tun_pkg.sv =====
// shared constants for the triangle unit normal block
// no dependencies; used by every module under rtl
`default_nettype none
package tun_pkg;
	localparam int unsigned COORD_WIDTH_DEF = 16;
	localparam int unsigned NORM_FRAC       = 14;
	localparam int unsigned SCALE_BITS      = 30;
	localparam int unsigned OUT_WIDTH       = 16;
	localparam int unsigned QUEUE_DEPTH     = 4;
endpackage
`default_nettype wire

// ===== rtl/triangle_unit_normal_top.sv =====
// top level of the triangle unit normal block
// depends on tun_pkg, tun_front, tun_fifo and tun_back
`default_nettype none
// Takes one triangle (three corners, signed Q8.8, COORD_WIDTH bits per
// coordinate) per transaction and returns its unit face normal in signed
// Q1.14, with tuser set and a zero vector when the corners are collinear or
// coincide. One triangle is accepted every cycle while the queue is not full;
// the path runs through the 31-step square root pipeline and the 15-step divide pipeline.
// A four-entry queue sits between the cross product front and the normalizing
// back so that an output stall does not stop input at once.
module triangle_unit_normal_top #(
	parameter int unsigned COORD_WIDTH = tun_pkg::COORD_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic      s_axis_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero padding
	input  wire logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic      m_axis_tvalid,
	input  wire logic m_axis_tready,
	// normal_x, normal_y, normal_z
	output logic [3*tun_pkg::OUT_WIDTH-1:0] m_axis_tdata,
	// degenerate
	output logic      m_axis_tuser
);
	import tun_pkg::*;

	localparam int unsigned EW = 3 * (2 * COORD_WIDTH + 1) + 4;

	logic          full, push, pop, avail;
	logic [EW-1:0] push_data, pop_data;

	tun_front #(.CW(COORD_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata[9*COORD_WIDTH-1:0]),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	tun_fifo #(.W(EW), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.not_empty (avail),
		.pop_data  (pop_data)
	);

	tun_back #(.CW(COORD_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (avail),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_degen (m_axis_tuser)
	);
endmodule
`default_nettype wire

// ===== rtl/tun_front.sv =====
// front part: takes triangles, forms edge vectors and the exact cross product
// depends on tun_pkg; pushes sign/magnitude components into tun_fifo
`default_nettype none
module tun_front #(
	parameter int unsigned CW = tun_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [9*CW-1:0]        in_data,
	input  wire logic                   full,
	output logic                        push,
	output logic [3*(2*CW+1)+3:0]       push_data
);
	import tun_pkg::*;

	localparam int unsigned CRW = 2 * CW + 1;

	logic              v_s1, v_s2, v_s3;
	logic signed [CW:0]       e_s1 [3];
	logic signed [CW:0]       f_s1 [3];
	logic signed [2*CW+1:0]   p_s2 [6];
	logic signed [2*CW+2:0]   cr_s3 [3];
	logic [2*CW+2:0]          ab [3];
	logic [CRW-1:0]           mg [3];
	logic [2:0]               ng;
	logic                     en;

	assign en       = !v_s3 || !full;
	assign in_ready = en;
	assign push     = v_s3 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// edge vectors b - a and c - a, exact in CW+1 bits
	for (genvar k = 0; k < 3; k++) begin : g_edge
		logic [CW-1:0] a, b, c;
		assign a = in_data[k*CW +: CW];
		assign b = in_data[(3+k)*CW +: CW];
		assign c = in_data[(6+k)*CW +: CW];
		always_ff @(posedge clk) begin
			if (en) begin
				e_s1[k] <= $signed({b[CW-1], b}) - $signed({a[CW-1], a});
				f_s1[k] <= $signed({c[CW-1], c}) - $signed({a[CW-1], a});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= e_s1[1] * f_s1[2];
			p_s2[1] <= e_s1[2] * f_s1[1];
			p_s2[2] <= e_s1[2] * f_s1[0];
			p_s2[3] <= e_s1[0] * f_s1[2];
			p_s2[4] <= e_s1[0] * f_s1[1];
			p_s2[5] <= e_s1[1] * f_s1[0];
			cr_s3[0] <= p_s2[0] - p_s2[1];
			cr_s3[1] <= p_s2[2] - p_s2[3];
			cr_s3[2] <= p_s2[4] - p_s2[5];
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_mag
		assign ng[k] = cr_s3[k][2*CW+2];
		assign ab[k] = ng[k] ? -cr_s3[k] : cr_s3[k];
		assign mg[k] = ab[k][CRW-1:0];
	end

	// top bit: all three components zero
	assign push_data = {(mg[0] == '0) && (mg[1] == '0) && (mg[2] == '0), ng,
		mg[2], mg[1], mg[0]};
endmodule
`default_nettype wire

// ===== rtl/tun_fifo.sv =====
// short queue between front and back parts
// depends on tun_pkg for the default depth
`default_nettype none
module tun_fifo #(
	parameter int unsigned W     = 8,
	parameter int unsigned DEPTH = tun_pkg::QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic              not_empty,
	output logic [W-1:0]      pop_data
);
	import tun_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned NW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [NW-1:0] cnt_q;

	assign full      = cnt_q == NW'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/tun_back.sv =====
// back part: scaling, sum of squares, pipelined square root and divide
// depends on tun_pkg; pops cross product components from tun_fifo
`default_nettype none
module tun_back #(
	parameter int unsigned CW = tun_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    avail,
	input  wire logic [3*(2*CW+1)+3:0]   pop_data,
	output logic                         pop,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [3*tun_pkg::OUT_WIDTH-1:0] out_data,
	output logic                         out_degen
);
	import tun_pkg::*;

	localparam int unsigned CRW = 2 * CW + 1;
	localparam int unsigned SB  = SCALE_BITS;
	localparam int unsigned MXW = (CRW > SB) ? CRW : SB;
	localparam int unsigned LW  = $clog2(MXW + 1);
	localparam int unsigned SQW = 2 * SB + 2;
	localparam int unsigned NQ  = SQW / 2;
	localparam int unsigned RTW = NQ;
	localparam int unsigned RMW = RTW + 3;
	localparam int unsigned QW  = NORM_FRAC + 1;
	localparam int unsigned NW  = SB + NORM_FRAC + 1;

	logic en;
	assign en  = !out_valid || out_ready;
	assign pop = en && avail;

	// stage 1: components from the queue
	logic           v_s1, dg_s1;
	logic [2:0]     ng_s1;
	logic [CRW-1:0] mg_s1 [3];
	// stage 2: common shift
	logic           v_s2, dg_s2;
	logic [2:0]     ng_s2;
	logic [CRW-1:0] mg_s2 [3];
	logic [LW-1:0]  sh_s2;
	// stage 3: scaled magnitudes
	logic           v_s3, dg_s3;
	logic [2:0]     ng_s3;
	logic [SB-1:0]  m_s3 [3];
	// stage 4: squares
	logic           v_s4, dg_s4;
	logic [2:0]     ng_s4;
	logic [SB-1:0]  m_s4 [3];
	logic [2*SB-1:0] sq_s4 [3];

	// square root pipeline, index 0 holds the sum
	logic           vq_s [0:NQ];
	logic           dq_s [0:NQ];
	logic [2:0]     nq_s [0:NQ];
	logic [SB-1:0]  mq_s [0:NQ][3];
	logic [SQW-1:0] sv_s [0:NQ];
	logic [RTW-1:0] rt_s [0:NQ];
	logic [RMW-1:0] rm_s [0:NQ];

	// divide pipeline, index 0 holds the dividends
	logic           vd_s [0:QW];
	logic           dd_s [0:QW];
	logic [2:0]     nd_s [0:QW];
	logic [RTW-1:0] dl_s [0:QW];
	logic [NW-1:0]  nr_s [0:QW][3];
	logic [QW-1:0]  qt_s [0:QW][3];

	logic [MXW-1:0] orv;
	logic [LW-1:0]  lb, sh;
	logic [RTW-1:0] len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= avail;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			out_valid <= vd_s[QW];
		end
	end

	// bit length of the largest component
	assign orv = MXW'(mg_s1[0] | mg_s1[1] | mg_s1[2]);
	always_comb begin
		lb = '0;
		for (int j = 0; j < MXW; j++) begin
			if (orv[j]) begin
				lb = LW'(j + 1);
			end
		end
	end
	assign sh = (lb > LW'(SB)) ? lb - LW'(SB) : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			dg_s1 <= pop_data[3*CRW+3];
			ng_s1 <= pop_data[3*CRW +: 3];
			dg_s2 <= dg_s1;
			ng_s2 <= ng_s1;
			sh_s2 <= sh;
			dg_s3 <= dg_s2;
			ng_s3 <= ng_s2;
			dg_s4 <= dg_s3;
			ng_s4 <= ng_s3;
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_front_lane
		logic [MXW-1:0] shv;
		assign shv = MXW'(mg_s2[k]) >> sh_s2;
		always_ff @(posedge clk) begin
			if (en) begin
				mg_s1[k] <= pop_data[k*CRW +: CRW];
				mg_s2[k] <= mg_s1[k];
				m_s3[k]  <= shv[SB-1:0];
				m_s4[k]  <= m_s3[k];
				sq_s4[k] <= m_s3[k] * m_s3[k];
				mq_s[0][k] <= m_s4[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vq_s[0] <= 1'b0;
		end else if (en) begin
			vq_s[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dq_s[0] <= dg_s4;
			nq_s[0] <= ng_s4;
			sv_s[0] <= SQW'(sq_s4[0]) + SQW'(sq_s4[1]) + SQW'(sq_s4[2]);
			rt_s[0] <= '0;
			rm_s[0] <= '0;
		end
	end

	// one root bit per stage, two radicand bits taken from the top
	for (genvar i = 1; i <= NQ; i++) begin : g_sqrt
		logic [RMW-1:0] cat, trial;
		logic           ge;
		assign cat   = {rm_s[i-1][RMW-3:0], sv_s[i-1][SQW-1-2*(i-1) -: 2]};
		assign trial = RMW'({rt_s[i-1], 2'b01});
		assign ge    = cat >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vq_s[i] <= 1'b0;
			end else if (en) begin
				vq_s[i] <= vq_s[i-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dq_s[i] <= dq_s[i-1];
				nq_s[i] <= nq_s[i-1];
				sv_s[i] <= sv_s[i-1];
				rm_s[i] <= ge ? cat - trial : cat;
				rt_s[i] <= {rt_s[i-1][RTW-2:0], ge};
				for (int k = 0; k < 3; k++) begin
					mq_s[i][k] <= mq_s[i-1][k];
				end
			end
		end
	end

	assign len = (rt_s[NQ] == '0) ? RTW'(1) : rt_s[NQ];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd_s[0] <= 1'b0;
		end else if (en) begin
			vd_s[0] <= vq_s[NQ];
		end
	end

	// dividend is m * 2^frac plus half the length, for rounding
	always_ff @(posedge clk) begin
		if (en) begin
			dd_s[0] <= dq_s[NQ];
			nd_s[0] <= nq_s[NQ];
			dl_s[0] <= len;
			for (int k = 0; k < 3; k++) begin
				nr_s[0][k] <= NW'({mq_s[NQ][k], {NORM_FRAC{1'b0}}}) + NW'(len >> 1);
				qt_s[0][k] <= '0;
			end
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_div
		logic [NW-1:0] dv;
		assign dv = NW'(dl_s[j-1]) << (QW - j);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd_s[j] <= 1'b0;
			end else if (en) begin
				vd_s[j] <= vd_s[j-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dd_s[j] <= dd_s[j-1];
				nd_s[j] <= nd_s[j-1];
				dl_s[j] <= dl_s[j-1];
				for (int k = 0; k < 3; k++) begin
					if (nr_s[j-1][k] >= dv) begin
						nr_s[j][k] <= nr_s[j-1][k] - dv;
						qt_s[j][k] <= {qt_s[j-1][k][QW-2:0], 1'b1};
					end else begin
						nr_s[j][k] <= nr_s[j-1][k];
						qt_s[j][k] <= {qt_s[j-1][k][QW-2:0], 1'b0};
					end
				end
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_out
		logic [OUT_WIDTH-1:0] qv;
		assign qv = OUT_WIDTH'(qt_s[QW][k]);
		always_ff @(posedge clk) begin
			if (en) begin
				out_data[k*OUT_WIDTH +: OUT_WIDTH] <= nd_s[QW][k] ? -qv : qv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_degen <= dd_s[QW];
		end
	end
endmodule
`default_nettype wire
